>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the separable image filter.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/sif_pkg.sv
// Package for the separable image filter: register codes and tap type.
// Depends on nothing.
package sif_pkg;

    localparam int NUM_TAPS = 5;
    localparam int TAP_W    = 16;
    localparam int CFG_IDX_W = 4;

    typedef logic signed [TAP_W-1:0] tap_t;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP0   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP1   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP2   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAP3   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAP4   = 4'd7;

endpackage

>>> rtl/sif_mac_cell.sv
// One cell of the multiply chain: multiplies a beat by a tap and registers it.
// Depends on sif_pkg for the tap type.
module sif_mac_cell
    import sif_pkg::*;
#(
    parameter int DATA_W = 17
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           data_valid,
    input  logic signed [DATA_W-1:0]       data,
    input  tap_t                           coef,
    output logic                           prod_valid,
    output logic signed [DATA_W+TAP_W-1:0] prod
);

    logic                           valid_reg;
    logic signed [DATA_W+TAP_W-1:0] prod_reg;

    // Valid flag travels with the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= data_valid;
        end
    end

    // Registered product.
    always_ff @(posedge clk)
    begin
        prod_reg <= (DATA_W+TAP_W)'(data) * (DATA_W+TAP_W)'(coef);
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

>>> rtl/separable_image_filter_top.sv
// Top level of the separable image filter: line store, sequencer, multiply chain.
// Depends on sif_pkg, sif_mac_cell and assert_macros.svh.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  pixel in  | pixel_valid / pixel_stall  | command, pixel_value
//  result    | result_valid / result_stall| filtered_value, frame_last
//  config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An item that gives no result frees the input at once; one that gives a result
// stalls it until the result is loaded, paced by the single read port of the line
// store, which feeds one window pixel per cycle into the two-cell multiply chain.
// Reset clears counters and control and loads default geometry; the line store and data registers are not cleared.
// A waiting result does not block the next item, only the next result.
`include "assert_macros.svh"
module separable_image_filter_top
    import sif_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 5,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic                 command,
    input  logic [15:0]          pixel_value,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic signed [31:0]   filtered_value,
    output logic                 frame_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int RS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = PIXEL_BITS + 1 + 2 * TAP_W;
    localparam int ACC_W  = (PIXEL_BITS + 40 > 58) ? PIXEL_BITS + 40 : 58;
    localparam int POS_W  = 27;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // Configuration registers.
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  window_reg;
    tap_t        taps_reg [NUM_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 16'd480;
            window_reg <= 3'd3;
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                taps_reg[t] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg   <= cfg_data[10:0];
                REG_HEIGHT: height_reg  <= cfg_data;
                REG_WINDOW: window_reg  <= cfg_data[2:0];
                REG_TAP0:   taps_reg[0] <= tap_t'(cfg_data);
                REG_TAP1:   taps_reg[1] <= tap_t'(cfg_data);
                REG_TAP2:   taps_reg[2] <= tap_t'(cfg_data);
                REG_TAP3:   taps_reg[3] <= tap_t'(cfg_data);
                REG_TAP4:   taps_reg[4] <= tap_t'(cfg_data);
                default:    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Effective geometry after clamping.
    logic [WW-1:0]    w_eff;
    logic [15:0]      h_eff;
    logic [WIN_W-1:0] win_eff;
    logic [WIN_W-1:0] pad;
    logic [31:0]      frame_len;
    logic [31:0]      lead_len;

    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        if (window_reg == 3'd0)
            win_eff = WIN_W'(1);
        else if (32'(window_reg) > 32'(MAX_WINDOW))
            win_eff = WIN_W'(MAX_WINDOW);
        else
            win_eff = WIN_W'(window_reg);
        pad       = win_eff >> 1;
        frame_len = 32'(h_eff) * 32'(w_eff);
        lead_len  = 32'(pad) * 32'(w_eff) + 32'(pad);
    end

    // Sequencer and position state.
    logic [1:0]       state_reg;
    logic [POS_W-1:0] in_pos_reg, out_pos_reg;
    logic [WW-1:0]    in_col_reg, out_col_reg;
    logic [RS_W-1:0]  in_rowm_reg, out_rowm_reg;
    logic [15:0]      out_row_reg;
    logic [WIN_W-1:0] g_reg, i_reg;
    logic             out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic             out_last_reg;

    logic pix_accept;
    logic in_frame;
    logic past_lead;
    logic issue;
    logic last_issue;
    logic chain_busy;
    logic out_load;
    logic is_last;

    assign pixel_stall = (state_reg != S_IDLE);
    assign pix_accept  = pixel_valid && !pixel_stall;
    assign in_frame    = 32'(in_pos_reg) < frame_len;
    assign past_lead   = 32'(in_pos_reg) >= lead_len;
    assign issue       = (state_reg == S_RUN);
    assign last_issue  = issue && (g_reg == win_eff - WIN_W'(1))
                               && (i_reg == win_eff - WIN_W'(1));
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);
    assign is_last     = (32'(out_pos_reg) + 32'd1) >= frame_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            in_col_reg   <= '0;
            out_col_reg  <= '0;
            in_rowm_reg  <= '0;
            out_rowm_reg <= '0;
            out_row_reg  <= '0;
            g_reg        <= '0;
            i_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pix_accept)
                    begin
                        if (in_col_reg == w_eff - WW'(1))
                        begin
                            in_col_reg  <= '0;
                            in_rowm_reg <= (in_rowm_reg == RS_W'(MAX_WINDOW - 1))
                                         ? '0 : in_rowm_reg + RS_W'(1);
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + WW'(1);
                        end
                        if (past_lead)
                        begin
                            state_reg <= S_RUN;
                            g_reg     <= '0;
                            i_reg     <= '0;
                        end
                        else
                        begin
                            in_pos_reg <= in_pos_reg + POS_W'(1);
                        end
                    end
                end
                S_RUN:
                begin
                    if (last_issue)
                        state_reg <= S_DRAIN;
                    else if (i_reg == win_eff - WIN_W'(1))
                    begin
                        i_reg <= '0;
                        g_reg <= g_reg + WIN_W'(1);
                    end
                    else
                        i_reg <= i_reg + WIN_W'(1);
                end
                S_DRAIN:
                begin
                    if (!chain_busy)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg     <= S_IDLE;
                        if (is_last)
                        begin
                            in_pos_reg   <= '0;
                            out_pos_reg  <= '0;
                            in_col_reg   <= '0;
                            in_rowm_reg  <= '0;
                            out_col_reg  <= '0;
                            out_rowm_reg <= '0;
                            out_row_reg  <= '0;
                        end
                        else
                        begin
                            in_pos_reg  <= in_pos_reg + POS_W'(1);
                            out_pos_reg <= out_pos_reg + POS_W'(1);
                            if (out_col_reg == w_eff - WW'(1))
                            begin
                                out_col_reg  <= '0;
                                out_row_reg  <= out_row_reg + 16'd1;
                                out_rowm_reg <= (out_rowm_reg == RS_W'(MAX_WINDOW - 1))
                                              ? '0 : out_rowm_reg + RS_W'(1);
                            end
                            else
                                out_col_reg <= out_col_reg + WW'(1);
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Line store write address and data.
    logic [31:0]           pv_wide;
    logic [PIXEL_BITS-1:0] wr_pix;
    logic [AW-1:0]         wr_addr;

    assign pv_wide = {16'd0, pixel_value};
    assign wr_pix  = command ? '0 : pv_wide[PIXEL_BITS-1:0];
    assign wr_addr = AW'(32'(in_rowm_reg) * MAX_WIDTH + 32'(in_col_reg));

    // Read address for window tap (g, i).
    logic signed [17:0] rr, cc;
    logic [5:0]         rs_sum;
    logic [RS_W-1:0]    rs_sel;
    logic               tap_inside;
    logic [AW-1:0]      rd_addr;

    always_comb
    begin
        rr = $signed({2'b0, out_row_reg}) + $signed(18'(g_reg)) - $signed(18'(pad));
        cc = $signed(18'(out_col_reg)) + $signed(18'(i_reg)) - $signed(18'(pad));
        rs_sum = 6'(out_rowm_reg) + 6'(MAX_WINDOW) + 6'(g_reg) - 6'(pad);
        if (rs_sum >= 6'(MAX_WINDOW))
            rs_sum = rs_sum - 6'(MAX_WINDOW);
        if (rs_sum >= 6'(MAX_WINDOW))
            rs_sum = rs_sum - 6'(MAX_WINDOW);
        rs_sel = rs_sum[RS_W-1:0];
        tap_inside = (rr >= 0) && (rr < $signed({2'b0, h_eff}))
                  && (cc >= 0) && (cc < $signed(18'(w_eff)));
        rd_addr = AW'(32'(rs_sel) * MAX_WIDTH + 32'(cc[WW-1:0]));
    end

    // Line store: one write and one registered read per cycle.
    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (pix_accept && in_frame)
            mem[wr_addr] <= wr_pix;
        rd_data_reg <= mem[rd_addr];
    end

    // Tap selection; taps beyond the register set count as zero.
    function automatic tap_t tap_sel(input logic [WIN_W-1:0] idx, input tap_t t0,
                                     input tap_t t1, input tap_t t2, input tap_t t3,
                                     input tap_t t4);
        tap_t r;
        case (32'(idx))
            0:       r = t0;
            1:       r = t1;
            2:       r = t2;
            3:       r = t3;
            4:       r = t4;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Stage aligned with the read data.
    logic s0_valid_reg, s0_inside_reg;
    tap_t s0_tg_reg, s0_ti_reg, a_ti_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        s0_inside_reg <= tap_inside;
        s0_tg_reg <= tap_sel(g_reg, taps_reg[0], taps_reg[1], taps_reg[2],
                             taps_reg[3], taps_reg[4]);
        s0_ti_reg <= tap_sel(i_reg, taps_reg[0], taps_reg[1], taps_reg[2],
                             taps_reg[3], taps_reg[4]);
        a_ti_reg  <= s0_ti_reg;
    end

    logic signed [PIXEL_BITS:0]            a_in;
    logic                                  a_valid, b_valid;
    logic signed [PIXEL_BITS+TAP_W:0]      a_prod;
    logic signed [PW-1:0]                  b_prod;

    assign a_in = s0_inside_reg ? $signed({1'b0, rd_data_reg}) : '0;

    // Vertical tap cell, then horizontal tap cell.
    sif_mac_cell #(.DATA_W(PIXEL_BITS + 1)) u_cell_v (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (s0_valid_reg),
        .data       (a_in),
        .coef       (s0_tg_reg),
        .prod_valid (a_valid),
        .prod       (a_prod)
    );

    sif_mac_cell #(.DATA_W(PIXEL_BITS + 1 + TAP_W)) u_cell_h (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (a_valid),
        .data       (a_prod),
        .coef       (a_ti_reg),
        .prod_valid (b_valid),
        .prod       (b_prod)
    );

    assign chain_busy = s0_valid_reg || a_valid || b_valid;

    // Accumulator, cleared whenever an item is accepted, before its window starts.
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (pix_accept)
            acc_reg <= '0;
        else if (b_valid)
            acc_reg <= acc_reg + {{(ACC_W-PW){b_prod[PW-1]}}, b_prod};
    end

    // Round half up, scale by 2^-24 and saturate.
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-25:0]   q;
    logic signed [31:0]         q_sat;

    always_comb
    begin
        acc_rnd = acc_reg + (ACC_W'(1) <<< 23);
        q       = acc_rnd[ACC_W-1:24];
        if (!q[ACC_W-25] && (q[ACC_W-25:31] != '0))
            q_sat = 32'sh7FFFFFFF;
        else if (q[ACC_W-25] && (q[ACC_W-25:31] != '1))
            q_sat = 32'sh80000000;
        else
            q_sat = q[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= q_sat;
            out_last_reg  <= is_last;
        end
    end

    assign result_valid   = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign frame_last     = out_last_reg;

    // The sum is complete before a result is formed.
    `SIF_ASSERT_NOW(a_chain_empty, clk, rst_n, state_reg == S_DONE, !chain_busy)
    // An item before the lead-in gives no work and frees the input at once.
    `SIF_ASSERT_NEXT(a_lead_idle, clk, rst_n, pix_accept && !past_lead, state_reg == S_IDLE)
    // A new result only ever comes from the finishing state.
    `SIF_ASSERT_NOW(a_out_src, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_DONE)

endmodule
